@@ src/dtmf_pkg.sv @@
`default_nettype none
package dtmf_pkg;

    localparam int NEIGHBORS_DEF = 16;
    localparam int TS_BITS_DEF   = 40;

    localparam int NB_FIELD_W = 4;
    localparam int DIST_W     = 10;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_W      = 16;
    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int Q_W        = 16;
    localparam int SCALE_W    = 19;
    localparam int SPROD_W    = Q_W + SCALE_W;
    localparam int SCALE_SH   = 20;
    localparam int DMAG_W     = SPROD_W - SCALE_SH;
    localparam int ROW_W      = 3 * DIST_W + 2;
    localparam int MUL_STEPS  = 9;

    localparam logic [SCALE_W-1:0] SCALE_Q20 = 19'd491967;

    localparam logic [CFG_W-1:0] UPPER_RST  = 10'd400;
    localparam logic [CFG_W-1:0] THRESH_RST = 10'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER  = 1'b0,
        CFG_THRESH = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              neg;
        logic [DMAG_W-1:0] dmag;
    } t_raw;

    typedef struct packed {
        logic              median_used;
        logic [DIST_W-1:0] distance;
    } t_hist_res;

    function automatic logic [DIST_W-1:0] med3(
        input logic [DIST_W-1:0] a,
        input logic [DIST_W-1:0] b,
        input logic [DIST_W-1:0] c
    );
        logic [DIST_W-1:0] m;
        if (a <= b && a <= c) begin
            m = (b <= c) ? b : c;
        end else if (b <= a && b <= c) begin
            m = (a <= c) ? a : c;
        end else begin
            m = (a <= b) ? a : b;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

@@ src/ds_twr_distance_median_filter.sv @@
// Double-sided two-way ranging distance with a per-neighbour median filter.
// Input beat on s_axis: neighbour index and six timestamps (poll, reply,
// final transmit/receive). Output beat on m_axis: filtered distance, an
// accepted flag and a median-used flag; exactly one output beat per input.
// Registers upper_limit (index 0) and outlier_threshold (index 1) are written
// through i_cfg_we / i_cfg_idx / i_cfg_wdata; write them only while the block
// idles, which the block itself does not enforce. One item at a time: the
// next input beat is taken only once the last result has left the sequencer;
// a rejected distance skips the history row. The processing time is set mostly
// by the 64-step restoring divider, plus nine partial products on a single
// 32x32 multiplier, a scaling multiply and a read-modify-write of the
// neighbour's history row (read, then written back in the next cycle).
// s_axis_tready is high while the sequencer is idle; the result sits in an
// output register, so the next item is taken while it waits for m_axis_tready.
// A stalled receiver holds the following result in the sequencer, which then
// stops taking input until the output register frees.
// Reset (synchronous, active low) restores the register defaults, empties the
// output register and marks every history row as all-zero samples at once.
`default_nettype none
module ds_twr_distance_median_filter #(
    parameter int NEIGHBORS      = dtmf_pkg::NEIGHBORS_DEF,
    parameter int TIMESTAMP_BITS = dtmf_pkg::TS_BITS_DEF,
    parameter int S_TDATA_W      = ((dtmf_pkg::NB_FIELD_W + 6 * TIMESTAMP_BITS + 7) / 8) * 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // neighbor, poll_tx, poll_rx, reply_tx, reply_rx, final_tx, final_rx
    input  wire logic [S_TDATA_W-1:0]           s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // distance, accepted, median_used
    output logic [dtmf_pkg::OUT_W-1:0]          m_axis_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic [dtmf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [dtmf_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import dtmf_pkg::*;

    localparam int NB_W = $clog2(NEIGHBORS);
    localparam int TS   = TIMESTAMP_BITS;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RANGE = 4'b0010,
        ST_HIST  = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_upper, r_thresh;
    logic [NB_W-1:0]     r_nb;
    logic [DIST_W+1:0]   r_res;
    logic                r_m_valid;
    logic [DIST_W+1:0]   r_m_data;

    logic                w_accept, w_rg_done, w_hist_done, w_ok, w_out_free;
    t_raw                w_raw;
    t_hist_res           w_hist;

    function automatic logic [NB_W-1:0] nb_wrap(input logic [NB_FIELD_W-1:0] nb);
        logic [NB_W-1:0] r;
        r = '0;
        for (int k = 0; k < (1 << NB_FIELD_W); k++) begin
            if (nb == NB_FIELD_W'(k)) begin
                r = NB_W'(k % NEIGHBORS);
            end
        end
        return r;
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    dtmf_range #(
        .TS_BITS (TS)
    ) u_range (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_poll_tx  (s_axis_tdata[NB_FIELD_W + 0*TS +: TS]),
        .i_poll_rx  (s_axis_tdata[NB_FIELD_W + 1*TS +: TS]),
        .i_reply_tx (s_axis_tdata[NB_FIELD_W + 2*TS +: TS]),
        .i_reply_rx (s_axis_tdata[NB_FIELD_W + 3*TS +: TS]),
        .i_final_tx (s_axis_tdata[NB_FIELD_W + 4*TS +: TS]),
        .i_final_rx (s_axis_tdata[NB_FIELD_W + 5*TS +: TS]),
        .o_done     (w_rg_done),
        .o_raw      (w_raw)
    );

    assign w_ok = !w_raw.neg && (w_raw.dmag != '0)
               && (w_raw.dmag < DMAG_W'(r_upper));

    dtmf_hist #(
        .NEIGHBORS (NEIGHBORS),
        .NB_W      (NB_W)
    ) u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  ((r_state == ST_RANGE) && w_rg_done && w_ok),
        .i_nb     (r_nb),
        .i_calc   (w_raw.dmag[DIST_W-1:0]),
        .i_thresh (r_thresh),
        .o_done   (w_hist_done),
        .o_res    (w_hist)
    );

    assign w_out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_nb <= nb_wrap(s_axis_tdata[NB_FIELD_W-1:0]);
        end
        if ((r_state == ST_RANGE) && w_rg_done && !w_ok) begin
            r_res <= '0;
        end else if ((r_state == ST_HIST) && w_hist_done) begin
            r_res <= {w_hist.median_used, 1'b1, w_hist.distance};
        end
        if ((r_state == ST_OUT) && w_out_free) begin
            r_m_data <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_upper   <= UPPER_RST;
            r_thresh  <= THRESH_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_UPPER:  r_upper  <= i_cfg_wdata;
                    CFG_THRESH: r_thresh <= i_cfg_wdata;
                    default:    r_upper  <= r_upper;
                endcase
            end
            if ((r_state == ST_OUT) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_RANGE;
                    end
                end
                ST_RANGE: begin
                    if (w_rg_done) begin
                        r_state <= w_ok ? ST_HIST : ST_OUT;
                    end
                end
                ST_HIST: begin
                    if (w_hist_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_W'(r_m_data);

endmodule
`default_nettype wire

@@ src/dtmf_range.sv @@
`default_nettype none
module dtmf_range #(
    parameter int TS_BITS = dtmf_pkg::TS_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [TS_BITS-1:0] i_poll_tx,
    input  wire logic [TS_BITS-1:0] i_poll_rx,
    input  wire logic [TS_BITS-1:0] i_reply_tx,
    input  wire logic [TS_BITS-1:0] i_reply_rx,
    input  wire logic [TS_BITS-1:0] i_final_tx,
    input  wire logic [TS_BITS-1:0] i_final_rx,
    output logic                    o_done,
    output dtmf_pkg::t_raw          o_raw
);
    import dtmf_pkg::*;

    localparam int DEN_W = TS_BITS + 2;

    typedef enum logic [7:0] {
        RG_IDLE = 8'b0000_0001,
        RG_PREP = 8'b0000_0010,
        RG_MUL  = 8'b0000_0100,
        RG_SGN  = 8'b0000_1000,
        RG_DIV  = 8'b0001_0000,
        RG_FIX  = 8'b0010_0000,
        RG_SCL  = 8'b0100_0000,
        RG_DONE = 8'b1000_0000
    } t_rg_state;

    t_rg_state           r_state;
    logic [TS_BITS-1:0]  r_rnd1, r_rep1, r_rnd2, r_rep2;
    logic [WORD_W-1:0]   r_d1, r_d2, r_num, r_pp, r_mag;
    logic [DEN_W-1:0]    r_den, r_rem;
    logic                r_pp_sh, r_pp_v, r_neg, r_qneg;
    logic [5:0]          r_cnt;
    logic [Q_W-1:0]      r_qmag;
    logic [SPROD_W-1:0]  r_prod;

    logic [WORD_W-1:0]   w_rep1, w_rep2, w_q;
    logic [HALF_W-1:0]   w_ma, w_mb;
    logic                w_msh;
    logic [DEN_W:0]      w_rem_sh, w_rem_sub;
    logic                w_ge;
    logic [Q_W-1:0]      w_q16;

    assign w_rep1 = WORD_W'(r_rep1);
    assign w_rep2 = WORD_W'(r_rep2);

    // wrapping 64-bit products from 32x32 partial products
    always_comb begin
        w_ma  = '0;
        w_mb  = '0;
        w_msh = 1'b0;
        case (r_cnt)
            6'd0: begin w_ma = r_d1[31:0];  w_mb = w_rep2[31:0];  end
            6'd1: begin w_ma = r_d1[31:0];  w_mb = w_rep2[63:32]; w_msh = 1'b1; end
            6'd2: begin w_ma = r_d1[63:32]; w_mb = w_rep2[31:0];  w_msh = 1'b1; end
            6'd3: begin w_ma = r_d2[31:0];  w_mb = w_rep1[31:0];  end
            6'd4: begin w_ma = r_d2[31:0];  w_mb = w_rep1[63:32]; w_msh = 1'b1; end
            6'd5: begin w_ma = r_d2[63:32]; w_mb = w_rep1[31:0];  w_msh = 1'b1; end
            6'd6: begin w_ma = r_d2[31:0];  w_mb = r_d1[31:0];    end
            6'd7: begin w_ma = r_d2[31:0];  w_mb = r_d1[63:32];   w_msh = 1'b1; end
            6'd8: begin w_ma = r_d2[63:32]; w_mb = r_d1[31:0];    w_msh = 1'b1; end
            default: begin w_ma = '0; w_mb = '0; w_msh = 1'b0; end
        endcase
    end

    assign w_rem_sh  = {r_rem, r_mag[WORD_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});

    assign w_q   = r_neg ? (WORD_W'(0) - r_mag) : r_mag;
    assign w_q16 = w_q[Q_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RG_IDLE;
            r_cnt   <= '0;
            r_pp_v  <= 1'b0;
        end else begin
            unique case (r_state)
                RG_IDLE: begin
                    if (i_start) begin
                        r_state <= RG_PREP;
                    end
                end
                RG_PREP: begin
                    r_cnt   <= '0;
                    r_pp_v  <= 1'b0;
                    r_state <= RG_MUL;
                end
                RG_MUL: begin
                    r_pp_v <= (r_cnt < 6'(MUL_STEPS));
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'(MUL_STEPS)) begin
                        r_state <= RG_SGN;
                    end
                end
                RG_SGN: begin
                    r_cnt   <= '0;
                    r_state <= RG_DIV;
                end
                RG_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(WORD_W - 1)) begin
                        r_state <= RG_FIX;
                    end
                end
                RG_FIX:  r_state <= RG_SCL;
                RG_SCL:  r_state <= RG_DONE;
                RG_DONE: r_state <= RG_IDLE;
                default: r_state <= RG_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            RG_IDLE: begin
                r_rnd1 <= i_reply_rx - i_poll_tx;
                r_rep1 <= i_reply_tx - i_poll_rx;
                r_rnd2 <= i_final_rx - i_reply_tx;
                r_rep2 <= i_final_tx - i_reply_rx;
            end
            RG_PREP: begin
                r_d1  <= WORD_W'(r_rnd1) - WORD_W'(r_rep1);
                r_d2  <= WORD_W'(r_rnd2) - WORD_W'(r_rep2);
                r_den <= (DEN_W'(r_rnd1) + DEN_W'(r_rnd2))
                       + (DEN_W'(r_rep1) + DEN_W'(r_rep2));
                r_num <= '0;
            end
            RG_MUL: begin
                r_pp    <= WORD_W'(w_ma) * WORD_W'(w_mb);
                r_pp_sh <= w_msh;
                if (r_pp_v) begin
                    r_num <= r_num + (r_pp_sh ? {r_pp[HALF_W-1:0], {HALF_W{1'b0}}} : r_pp);
                end
            end
            RG_SGN: begin
                r_neg <= r_num[WORD_W-1];
                r_mag <= r_num[WORD_W-1] ? (WORD_W'(0) - r_num) : r_num;
                r_rem <= '0;
            end
            RG_DIV: begin
                // restoring divide, quotient bits shift in behind the dividend
                r_rem <= w_ge ? w_rem_sub[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
                r_mag <= {r_mag[WORD_W-2:0], w_ge};
            end
            RG_FIX: begin
                if (r_den == '0) begin
                    r_qneg <= 1'b0;
                    r_qmag <= '0;
                end else begin
                    r_qneg <= w_q16[Q_W-1];
                    r_qmag <= w_q16[Q_W-1]
                            ? Q_W'((Q_W+1)'(1 << Q_W) - (Q_W+1)'(w_q16)) : w_q16;
                end
            end
            RG_SCL: begin
                r_prod <= SPROD_W'(r_qmag) * SPROD_W'(SCALE_Q20);
            end
            default: begin
            end
        endcase
    end

    assign o_done     = (r_state == RG_DONE);
    assign o_raw.neg  = r_qneg;
    assign o_raw.dmag = r_prod[SPROD_W-1:SCALE_SH];

endmodule
`default_nettype wire

@@ src/dtmf_hist.sv @@
`default_nettype none
module dtmf_hist #(
    parameter int NEIGHBORS = dtmf_pkg::NEIGHBORS_DEF,
    parameter int NB_W      = $clog2(NEIGHBORS)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [NB_W-1:0]             i_nb,
    input  wire logic [dtmf_pkg::DIST_W-1:0] i_calc,
    input  wire logic [dtmf_pkg::CFG_W-1:0]  i_thresh,
    output logic                             o_done,
    output dtmf_pkg::t_hist_res              o_res
);
    import dtmf_pkg::*;

    logic [ROW_W-1:0]  r_mem [NEIGHBORS];
    logic [NEIGHBORS-1:0] r_vld;
    logic [ROW_W-1:0]  r_rd;
    logic              r_vld_rd, r_busy;
    logic [NB_W-1:0]   r_nb;
    logic [DIST_W-1:0] r_calc;

    logic [ROW_W-1:0]  w_row, w_row_new;
    logic [DIST_W-1:0] w_s0, w_s1, w_s2, w_med, w_gap;
    logic [1:0]        w_pos, w_pos_nx;

    assign w_row = r_vld_rd ? r_rd : '0;
    assign w_s0  = w_row[DIST_W-1:0];
    assign w_s1  = w_row[2*DIST_W-1:DIST_W];
    assign w_s2  = w_row[3*DIST_W-1:2*DIST_W];
    assign w_pos = w_row[ROW_W-1:3*DIST_W];
    assign w_med = med3(w_s0, w_s1, w_s2);
    assign w_gap = (w_med >= r_calc) ? (w_med - r_calc) : (r_calc - w_med);

    assign w_pos_nx = (w_pos >= 2'd2) ? 2'd0 : (w_pos + 2'd1);

    always_comb begin
        w_row_new = {w_pos_nx, w_s2, w_s1, w_s0};
        case (w_pos_nx)
            2'd0:    w_row_new[DIST_W-1:0]          = r_calc;
            2'd1:    w_row_new[2*DIST_W-1:DIST_W]   = r_calc;
            default: w_row_new[3*DIST_W-1:2*DIST_W] = r_calc;
        endcase
    end

    // row memory: read on start, write back in the following cycle
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_nb] <= w_row_new;
        end
        if (i_start) begin
            r_rd <= r_mem[i_nb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nb     <= i_nb;
            r_calc   <= i_calc;
            r_vld_rd <= r_vld[i_nb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
            if (r_busy) begin
                r_vld[r_nb] <= 1'b1;
            end
        end
    end

    assign o_done            = r_busy;
    assign o_res.median_used = (w_gap > i_thresh);
    assign o_res.distance    = (w_gap > i_thresh) ? w_med : r_calc;

endmodule
`default_nettype wire
